### rtl/core/affinv_pkg.sv
package affinv_pkg;

  // Element, cofactor and determinant widths of the Q.F datapath.
  localparam int ELEM_W  = 32;
  localparam int ADJ_W   = 64;
  localparam int PROD_W  = 96;
  localparam int DET_W   = 98;
  localparam int FLOOR_W = 48;
  localparam int ROW_W   = 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 64;

  // Divider depth: one setup stage, one stage per quotient bit, one rounding stage.
  localparam int DIV_LAT = ELEM_W + 2;

  localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;
  localparam logic [ROW_W-1:0] ROW_LAST  = 2'd2;

  // Register map, word index taken from address bit 3.
  localparam logic REG_DET_FLOOR = 1'b0;

  localparam logic [FLOOR_W-1:0] DET_FLOOR_RESET = 48'd1;

  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic             sing;
  } sband_t;

endpackage

### rtl/core/affinv_front.sv
module affinv_front #(
  parameter int FRAC_BITS = 16,
  localparam int NUM_W = affinv_pkg::DET_W + 1 + FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic signed [affinv_pkg::ELEM_W-1:0]   elem [12],
  input  logic [affinv_pkg::FLOOR_W-1:0]         det_floor,
  output logic                                   out_valid,
  output logic signed [NUM_W-1:0]                num [3][4],
  output logic [affinv_pkg::DET_W-1:0]           dm,
  output logic                                   dneg,
  output logic                                   sing
);
  import affinv_pkg::*;

  logic [6:0] v;

  logic signed [ELEM_W-1:0] m1 [12];
  logic signed [ADJ_W-1:0]  p2 [9][2];
  logic signed [ELEM_W-1:0] x2 [6];
  logic signed [ADJ_W-1:0]  adj3 [9];
  logic signed [ELEM_W-1:0] x3 [6];
  logic signed [ADJ_W:0]    lo4 [12];
  logic signed [ADJ_W-1:0]  hi4 [12];
  logic signed [ADJ_W-1:0]  adj4 [9];
  logic signed [PROD_W-1:0] pr5 [12];
  logic signed [ADJ_W-1:0]  adj5 [9];
  logic signed [DET_W-1:0]  det6;
  logic signed [DET_W-1:0]  tn6 [3];
  logic signed [ADJ_W-1:0]  adj6 [9];

  // Entry 0..2 are the determinant terms, 3+3i+j the translation terms.
  logic signed [ELEM_W-1:0] mul_x [12];
  logic signed [ADJ_W-1:0]  mul_y [12];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mul_x[i] = x3[i];
      mul_y[i] = adj3[3*i];
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mul_x[3+3*i+j] = x3[3+j];
        mul_y[3+3*i+j] = adj3[3*i+j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:0], in_valid};
    end
  end

  assign out_valid = v[6];

  always_ff @(posedge clk) begin
    if (en) begin
      m1 <= elem;
      // a b c / d e f / g h k sit at 0 1 2 / 4 5 6 / 8 9 10.
      p2[0][0] <= m1[5] * m1[10];  p2[0][1] <= m1[6] * m1[9];
      p2[1][0] <= m1[2] * m1[9];   p2[1][1] <= m1[1] * m1[10];
      p2[2][0] <= m1[1] * m1[6];   p2[2][1] <= m1[2] * m1[5];
      p2[3][0] <= m1[6] * m1[8];   p2[3][1] <= m1[4] * m1[10];
      p2[4][0] <= m1[0] * m1[10];  p2[4][1] <= m1[2] * m1[8];
      p2[5][0] <= m1[2] * m1[4];   p2[5][1] <= m1[0] * m1[6];
      p2[6][0] <= m1[4] * m1[9];   p2[6][1] <= m1[5] * m1[8];
      p2[7][0] <= m1[1] * m1[8];   p2[7][1] <= m1[0] * m1[9];
      p2[8][0] <= m1[0] * m1[5];   p2[8][1] <= m1[1] * m1[4];
      x2 <= '{m1[0], m1[1], m1[2], m1[3], m1[7], m1[11]};
      for (int i = 0; i < 9; i++) begin
        adj3[i] <= p2[i][0] - p2[i][1];
      end
      x3 <= x2;
      for (int i = 0; i < 12; i++) begin
        lo4[i] <= mul_x[i] * $signed({1'b0, mul_y[i][ELEM_W-1:0]});
        hi4[i] <= mul_x[i] * $signed(mul_y[i][ADJ_W-1:ELEM_W]);
      end
      adj4 <= adj3;
      for (int i = 0; i < 12; i++) begin
        pr5[i] <= (PROD_W'(hi4[i]) <<< ELEM_W) + PROD_W'(lo4[i]);
      end
      adj5 <= adj4;
      det6 <= DET_W'(pr5[0]) + DET_W'(pr5[1]) + DET_W'(pr5[2]);
      for (int i = 0; i < 3; i++) begin
        tn6[i] <= DET_W'(pr5[3+3*i]) + DET_W'(pr5[4+3*i]) + DET_W'(pr5[5+3*i]);
      end
      adj6 <= adj5;
      dm   <= det6[DET_W-1] ? DET_W'(-det6) : DET_W'(det6);
      dneg <= det6[DET_W-1];
      sing <= (det6 == '0) ||
              ((det6[DET_W-1] ? DET_W'(-det6) : DET_W'(det6)) < DET_W'(det_floor));
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          num[i][j] <= NUM_W'(adj6[3*i+j]) <<< (2 * FRAC_BITS);
        end
        num[i][3] <= -(NUM_W'(tn6[i]) <<< FRAC_BITS);
      end
    end
  end

endmodule

### rtl/core/affinv_div.sv
module affinv_div #(
  parameter int NUM_W = 115
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [NUM_W-1:0]            num,
  input  logic [affinv_pkg::DET_W-1:0]       dm,
  input  logic                               dneg,
  output logic [affinv_pkg::ELEM_W-1:0]      quo,
  output logic                               sat
);
  import affinv_pkg::*;

  localparam int QW   = ELEM_W;
  localparam int HI_W = NUM_W - QW;
  localparam int CW   = (HI_W > DET_W) ? HI_W : DET_W;

  logic [NUM_W-1:0] mag;
  logic [HI_W-1:0]  mag_hi;

  logic [DET_W-1:0] r  [QW+1];
  logic [QW-1:0]    n  [QW+1];
  logic [QW-1:0]    q  [QW+1];
  logic [DET_W-1:0] d  [QW+1];
  logic             ng [QW+1];
  logic             ov [QW+1];

  logic          rnd;
  logic [QW:0]   qr;
  logic [QW:0]   lim;
  logic          clamp;

  assign mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign mag_hi = mag[NUM_W-1:QW];

  // Setup: a quotient of 2^32 or more always clamps; otherwise the high part
  // of the numerator is already below the divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      r[0]  <= DET_W'(mag_hi);
      n[0]  <= mag[QW-1:0];
      q[0]  <= '0;
      d[0]  <= dm;
      ng[0] <= num[NUM_W-1] ^ dneg;
      ov[0] <= CW'(mag_hi) >= CW'(dm);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DET_W:0] t;
    logic [DET_W:0] diff;
    logic           ge;

    assign t    = {r[k], n[k][QW-1]};
    assign diff = t - {1'b0, d[k]};
    assign ge   = t >= {1'b0, d[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        r[k+1]  <= ge ? diff[DET_W-1:0] : t[DET_W-1:0];
        n[k+1]  <= n[k] << 1;
        q[k+1]  <= {q[k][QW-2:0], ge};
        d[k+1]  <= d[k];
        ng[k+1] <= ng[k];
        ov[k+1] <= ov[k];
      end
    end
  end

  // Round half away from zero on the magnitude, then clamp to 32 bits.
  assign rnd   = {r[QW], 1'b0} >= {1'b0, d[QW]};
  assign qr    = {1'b0, q[QW]} + (QW+1)'(rnd);
  assign lim   = ng[QW] ? ((QW+1)'(1) << (QW-1)) : (((QW+1)'(1) << (QW-1)) - 1'b1);
  assign clamp = ov[QW] || (qr > lim);

  always_ff @(posedge clk) begin
    if (en) begin
      sat <= clamp;
      if (clamp) begin
        quo <= ng[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      end else begin
        quo <= ng[QW] ? QW'(-qr) : qr[QW-1:0];
      end
    end
  end

endmodule

### rtl/core/affine_matrix_inverse.sv
// Affine 3x4 matrix inverse by cofactors, signed fixed point Q.FRAC_BITS.
//
// Input channel: one word is a whole transform, twelve elements a00..a23,
// taken at a clock edge where item_valid is high and item_stall is low.
// Output channel: each transform gives three words, rows 0, 1 and 2 of
// [A^-1 | -A^-1 t] in that order; last marks row 2. singular reports a
// determinant below det_floor (or zero), in which case the rows are identity.
// saturated marks a row in which some element was clamped to 32 bits.
//
// A new word is taken only once the row sequencer is idle or on the last row
// of the previous transform, as the single row-wide divider array serves one
// output row per cycle while row_stall does not hold it; the cofactor front
// end could take a word every cycle.
//
// When row_stall is high with a row waiting, the whole row pipeline holds,
// and item_stall rises as soon as the front end has nowhere to hand a word.
// Reset clears all valid bits and sets det_floor to 1. The configuration
// port is APB-like, 64-bit data, det_floor at byte address 0.
module affine_matrix_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic signed [affinv_pkg::ELEM_W-1:0]  a00,
  input  logic signed [affinv_pkg::ELEM_W-1:0]  a01,
  input  logic signed [affinv_pkg::ELEM_W-1:0]  a02,
  input  logic signed [affinv_pkg::ELEM_W-1:0]  a03,
  input  logic signed [affinv_pkg::ELEM_W-1:0]  a10,
  input  logic signed [affinv_pkg::ELEM_W-1:0]  a11,
  input  logic signed [affinv_pkg::ELEM_W-1:0]  a12,
  input  logic signed [affinv_pkg::ELEM_W-1:0]  a13,
  input  logic signed [affinv_pkg::ELEM_W-1:0]  a20,
  input  logic signed [affinv_pkg::ELEM_W-1:0]  a21,
  input  logic signed [affinv_pkg::ELEM_W-1:0]  a22,
  input  logic signed [affinv_pkg::ELEM_W-1:0]  a23,
  output logic                                  row_valid,
  input  logic                                  row_stall,
  output logic [affinv_pkg::ROW_W-1:0]          row_index,
  output logic signed [affinv_pkg::ELEM_W-1:0]  col0,
  output logic signed [affinv_pkg::ELEM_W-1:0]  col1,
  output logic signed [affinv_pkg::ELEM_W-1:0]  col2,
  output logic signed [affinv_pkg::ELEM_W-1:0]  col3,
  output logic                                  singular,
  output logic                                  saturated,
  output logic                                  last,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [affinv_pkg::ADDR_W-1:0]         paddr,
  input  logic [affinv_pkg::DATA_W-1:0]         pwdata,
  output logic [affinv_pkg::DATA_W-1:0]         prdata,
  output logic                                  pready
);
  import affinv_pkg::*;

  localparam int NUM_W = DET_W + 1 + FRAC_BITS;

  logic [FLOOR_W-1:0] det_floor;

  logic back_en;
  logic front_en;

  logic signed [ELEM_W-1:0] elem [12];
  logic                     f_valid;
  logic signed [NUM_W-1:0]  f_num [3][4];
  logic [DET_W-1:0]         f_dm;
  logic                     f_dneg;
  logic                     f_sing;

  logic                     ser_valid;
  logic [ROW_W-1:0]         ser_row;
  logic signed [NUM_W-1:0]  ser_num [3][4];
  logic [DET_W-1:0]         ser_dm;
  logic                     ser_dneg;
  logic                     ser_sing;

  sband_t                   sb [DIV_LAT];
  logic [ELEM_W-1:0]        quo [4];
  logic [3:0]               qsat;
  logic [ELEM_W-1:0]        one_q;

  // Configuration: one 48-bit register, always ready.
  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_DET_FLOOR) ? DATA_W'(det_floor) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_floor <= DET_FLOOR_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[3] == REG_DET_FLOOR)) begin
      det_floor <= pwdata[FLOOR_W-1:0];
    end
  end

  // The row pipeline moves unless a finished row is held at the output.
  // The front end moves when the row pipeline does and the row sequencer is free or on its last row.
  assign back_en    = !(row_valid && row_stall);
  assign front_en   = back_en && (!ser_valid || (ser_row == ROW_LAST));
  assign item_stall = !front_en;

  assign elem = '{a00, a01, a02, a03, a10, a11, a12, a13, a20, a21, a22, a23};

  affinv_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (front_en),
    .in_valid  (item_valid),
    .elem      (elem),
    .det_floor (det_floor),
    .out_valid (f_valid),
    .num       (f_num),
    .dm        (f_dm),
    .dneg      (f_dneg),
    .sing      (f_sing)
  );

  // Row sequencer: holds one transform and issues its three rows.
  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_row   <= ROW_FIRST;
    end else if (front_en) begin
      ser_valid <= f_valid;
      ser_row   <= ROW_FIRST;
    end else if (back_en && ser_valid) begin
      ser_row <= ser_row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      ser_num  <= f_num;
      ser_dm   <= f_dm;
      ser_dneg <= f_dneg;
      ser_sing <= f_sing;
    end
  end

  // Four divider lanes: three linear elements and the translation.
  for (genvar j = 0; j < 4; j++) begin : g_lane
    affinv_div #(
      .NUM_W (NUM_W)
    ) u_div (
      .clk  (clk),
      .en   (back_en),
      .num  (ser_num[ser_row][j]),
      .dm   (ser_dm),
      .dneg (ser_dneg),
      .quo  (quo[j]),
      .sat  (qsat[j])
    );
  end

  // Row number, singular flag and valid bit travel alongside the dividers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        sb[k] <= '0;
      end
    end else if (back_en) begin
      sb[0] <= '{valid: ser_valid, row: ser_row, sing: ser_sing};
      for (int k = 1; k < DIV_LAT; k++) begin
        sb[k] <= sb[k-1];
      end
    end
  end

  // A singular transform answers with identity rows; its division results
  // are meaningless and are replaced here.
  assign one_q     = ELEM_W'(1) << FRAC_BITS;
  assign row_valid = sb[DIV_LAT-1].valid;
  assign row_index = sb[DIV_LAT-1].row;
  assign singular  = sb[DIV_LAT-1].sing;
  assign last      = (sb[DIV_LAT-1].row == ROW_LAST);
  assign saturated = !singular && (|qsat);

  always_comb begin
    if (singular) begin
      col0 = (row_index == 2'd0) ? one_q : '0;
      col1 = (row_index == 2'd1) ? one_q : '0;
      col2 = (row_index == 2'd2) ? one_q : '0;
      col3 = '0;
    end else begin
      col0 = quo[0];
      col1 = quo[1];
      col2 = quo[2];
      col3 = quo[3];
    end
  end

endmodule

### tb/affinv_checker.sv
`timescale 1ns / 100ps

module affinv_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic [31:0] a00, a01, a02, a03,
  input  logic [31:0] a10, a11, a12, a13,
  input  logic [31:0] a20, a21, a22, a23,
  input  logic        row_valid,
  input  logic        row_stall,
  input  logic [1:0]  row_index,
  input  logic [31:0] col0, col1, col2, col3,
  input  logic        singular,
  input  logic        saturated,
  input  logic        last,
  input  logic [47:0] floor_now,
  output int          fail_count,
  output int          rows_pending
);

  typedef struct packed {
    logic [1:0]  idx;
    logic [31:0] c0, c1, c2, c3;
    logic        sing, sat, lst;
  } inv_row_t;

  inv_row_t expected_rows[$];

  assign rows_pending = expected_rows.size();

  // Rounded signed quotient num/den, ties away from zero, clamped to 32 bits.
  function automatic logic [31:0] div_round(input logic signed [255:0] num,
                                            input logic signed [255:0] den,
                                            inout logic sat);
    logic [255:0] n, d, q, r;
    logic neg;
    n = num[255] ? -num : num;
    d = den[255] ? -den : den;
    neg = num[255] ^ den[255];
    q = n / d;
    r = n % d;
    if ((r << 1) >= d) q = q + 1;
    if (!neg && q > 256'h7FFFFFFF) begin
      sat = 1'b1;
      return 32'h7FFFFFFF;
    end
    if (neg && q > 256'h80000000) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  task automatic predict_inverse(input logic [31:0] w[12]);
    logic signed [255:0] m[3][4];
    logic signed [255:0] adj[3][3];
    logic signed [255:0] det, tn, dmag;
    logic sing, sat;
    logic [31:0] lin[3];
    inv_row_t row;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 4; j++) m[i][j] = $signed(w[i*4+j]);
    adj[0][0] = m[1][1]*m[2][2] - m[1][2]*m[2][1];
    adj[0][1] = m[0][2]*m[2][1] - m[0][1]*m[2][2];
    adj[0][2] = m[0][1]*m[1][2] - m[0][2]*m[1][1];
    adj[1][0] = m[1][2]*m[2][0] - m[1][0]*m[2][2];
    adj[1][1] = m[0][0]*m[2][2] - m[0][2]*m[2][0];
    adj[1][2] = m[0][2]*m[1][0] - m[0][0]*m[1][2];
    adj[2][0] = m[1][0]*m[2][1] - m[1][1]*m[2][0];
    adj[2][1] = m[0][1]*m[2][0] - m[0][0]*m[2][1];
    adj[2][2] = m[0][0]*m[1][1] - m[0][1]*m[1][0];
    det = m[0][0]*adj[0][0] + m[0][1]*adj[1][0] + m[0][2]*adj[2][0];
    dmag = det[255] ? -det : det;
    sing = (dmag == 0) || (dmag < $signed({208'd0, floor_now}));
    for (int i = 0; i < 3; i++) begin
      sat = 1'b0;
      if (sing) begin
        for (int j = 0; j < 3; j++) lin[j] = (i == j) ? 32'h10000 : 32'h0;
        row.c3 = 32'h0;
      end else begin
        tn = 0;
        for (int j = 0; j < 3; j++) begin
          lin[j] = div_round(adj[i][j] <<< 32, det, sat);
          tn = tn + adj[i][j] * m[j][3];
        end
        row.c3 = div_round(-(tn <<< 16), det, sat);
      end
      row.idx = i[1:0];
      row.c0 = lin[0];
      row.c1 = lin[1];
      row.c2 = lin[2];
      row.sing = sing;
      row.sat = sat;
      row.lst = (i == 2);
      expected_rows.push_back(row);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    logic [31:0] w[12];
    inv_row_t want;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        w = '{a00, a01, a02, a03, a10, a11, a12, a13, a20, a21, a22, a23};
        predict_inverse(w);
      end
      if (row_valid && !row_stall) begin
        if (expected_rows.size() == 0) begin
          report_mismatch("row with nothing expected");
        end else begin
          want = expected_rows.pop_front();
          if (row_index !== want.idx) report_mismatch("row_index");
          if (col0 !== want.c0) report_mismatch($sformatf("col0 %h want %h", col0, want.c0));
          if (col1 !== want.c1) report_mismatch($sformatf("col1 %h want %h", col1, want.c1));
          if (col2 !== want.c2) report_mismatch($sformatf("col2 %h want %h", col2, want.c2));
          if (col3 !== want.c3) report_mismatch($sformatf("col3 %h want %h", col3, want.c3));
          if (singular !== want.sing) report_mismatch("singular");
          if (saturated !== want.sat) report_mismatch("saturated");
          if (last !== want.lst) report_mismatch("last");
        end
      end
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import affinv_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [31:0] a[12];
  logic row_valid;
  logic row_stall = 1'b0;
  logic [ROW_W-1:0] row_index;
  logic [ELEM_W-1:0] col0, col1, col2, col3;
  logic singular, saturated, last;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // The checker predicts with whatever floor the testbench last wrote.
  logic [FLOOR_W-1:0] floor_now = DET_FLOOR_RESET;
  int fail_count, rows_pending;

  // Idling controls: percentages of cycles in which each side holds back.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit long_hold = 1'b0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  initial for (int i = 0; i < 12; i++) a[i] = '0;

  affine_matrix_inverse u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .a00(a[0]), .a01(a[1]), .a02(a[2]), .a03(a[3]),
    .a10(a[4]), .a11(a[5]), .a12(a[6]), .a13(a[7]),
    .a20(a[8]), .a21(a[9]), .a22(a[10]), .a23(a[11]),
    .row_valid(row_valid), .row_stall(row_stall), .row_index(row_index),
    .col0(col0), .col1(col1), .col2(col2), .col3(col3),
    .singular(singular), .saturated(saturated), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  affinv_checker u_checker (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_stall(item_stall),
    .a00(a[0]), .a01(a[1]), .a02(a[2]), .a03(a[3]),
    .a10(a[4]), .a11(a[5]), .a12(a[6]), .a13(a[7]),
    .a20(a[8]), .a21(a[9]), .a22(a[10]), .a23(a[11]),
    .row_valid(row_valid), .row_stall(row_stall), .row_index(row_index),
    .col0(col0), .col1(col1), .col2(col2), .col3(col3),
    .singular(singular), .saturated(saturated), .last(last),
    .floor_now(floor_now), .fail_count(fail_count), .rows_pending(rows_pending)
  );

  // The receiver stalls at random, or holds off completely for a long stretch
  // while the sender keeps offering words so that the pipeline backs up.
  always @(posedge clk) begin
    if (long_hold) row_stall <= 1'b1;
    else row_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: too many cycles in a row without any handshake ends the run.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (row_valid && !row_stall) || rst || long_hold)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("FAIL");
      $finish;
    end
  end

  // Random element with a bias toward values that produce interesting cases.
  function automatic logic [31:0] pick_elem();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      2: return $signed($urandom_range(8)) - 4;
      3: return 32'($signed($urandom_range(262144)) - 131072);
      default: return 32'($signed($urandom_range(32'h3FFFF)) - 32'h1FFFF) <<< 4;
    endcase
  endfunction

  task automatic apb_write_floor(input logic [FLOOR_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= ({$urandom, $urandom} & 64'hFFFF_0000_0000_0000) | 64'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    floor_now <= value;
  endtask

  // Offer one word and hold it until the block takes it. Valid stays high
  // afterwards so that the next word can follow without a gap.
  task automatic send_matrix(input logic [31:0] m[12]);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    for (int i = 0; i < 12; i++) a[i] <= m[i];
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // Stop offering, then wait until every expected row has come.
  task automatic drain();
    item_valid <= 1'b0;
    while (rows_pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    logic [31:0] m[12];
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 12; i++) m[i] = pick_elem();
      case ($urandom_range(7))
        // Duplicate a row so the determinant is exactly zero.
        0: for (int j = 0; j < 3; j++) m[8+j] = m[j];
        // Random diagonal with small off-diagonal terms and random translation.
        1: begin
          for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
              m[i*4+j] = (i == j) ? 32'($urandom_range(32'h40000, 1)) : $urandom_range(4095);
        end
        default: ;
      endcase
      send_matrix(m);
    end
  endtask

  initial begin
    logic [31:0] m[12];
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: identity, zero, extremes, tiny and huge determinants.
    for (int d = 0; d < 14; d++) begin
      for (int i = 0; i < 12; i++) m[i] = 32'h0;
      case (d)
        0: begin m[0] = 32'h10000; m[5] = 32'h10000; m[10] = 32'h10000; end
        1: ;
        2: for (int i = 0; i < 12; i++) m[i] = 32'h7FFFFFFF;
        3: for (int i = 0; i < 12; i++) m[i] = 32'h80000000;
        4: begin m[0] = 32'h80000000; m[5] = 32'h7FFFFFFF; m[10] = 32'h80000000;
                 m[3] = 32'h7FFFFFFF; m[7] = 32'h80000000; m[11] = 32'hFFFFFFFF; end
        5: begin m[0] = 1; m[5] = 1; m[10] = 1; m[3] = 32'h7FFFFFFF; end
        6: begin m[0] = 1; m[5] = 1; m[10] = 2; end
        7: begin m[0] = 32'hFFFFFFFF; m[5] = 1; m[10] = 1; m[11] = 32'h80000000; end
        8: begin m[1] = 32'h20000; m[4] = 32'hFFFF0000; m[10] = 32'h30000;
                 m[3] = 32'h12345; m[7] = 32'hFEDCBA98; m[11] = 32'h55555; end
        9: begin m[0] = 32'h7FFFFFFF; m[5] = 32'h7FFFFFFF; m[10] = 32'h7FFFFFFF; end
        10: begin m[0] = 3; m[5] = 32'h10000; m[10] = 32'h10000; m[3] = 32'h18000; end
        11: begin m[0] = 32'h10000; m[1] = 32'h10000; m[4] = 32'h10000; m[5] = 32'h10000;
                  m[10] = 32'h10000; end
        12: for (int i = 0; i < 12; i++) m[i] = $urandom;
        13: begin m[0] = 32'h5555AAAA; m[5] = 32'hAAAA5555; m[10] = 32'h0F0F0F0F;
                  m[3] = 32'hF0F0F0F0; m[7] = 32'h33333333; m[11] = 32'hCCCCCCCC; end
      endcase
      send_matrix(m);
    end
    drain();

    // A floor of zero: only an exactly zero determinant is singular.
    apb_write_floor('0);
    for (int i = 0; i < 12; i++) m[i] = 32'h0;
    m[0] = 1; m[5] = 1; m[10] = 1;
    send_matrix(m);
    send_random(20);
    drain();

    // Phase: no idling, then the sender idles most of the time.
    apb_write_floor(48'd1 << 40);
    send_random(60);
    send_idle_pct = 67;
    send_random(50);
    drain();

    // Largest floor: more determinants count as singular; the receiver stalls most of the time.
    apb_write_floor({FLOOR_W{1'b1}});
    send_idle_pct = 0;
    recv_stall_pct = 67;
    send_random(50);
    drain();

    // Long receiver hold-off while words keep coming, to fill the pipeline.
    apb_write_floor(48'h0000_8000_0000);
    recv_stall_pct = 0;
    long_hold <= 1'b1;
    fork
      send_random(30);
      begin
        repeat (300) @(posedge clk);
        long_hold <= 1'b0;
      end
    join
    drain();

    // Both sides idle occasionally, reset-valued floor restored.
    apb_write_floor(48'd1);
    send_idle_pct = 7;
    recv_stall_pct = 7;
    send_random(90);
    drain();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
